/* rtl/core/tmps_pkg.sv */
// Shared widths, register codes, cell control type and saturating add for the path-sum block.
package tmps_pkg;

   localparam int MAX_LEVELS_DEFAULT = 128;
   localparam int VALUE_W            = 16;
   localparam int SUM_W              = 32;
   localparam int BEST_W             = 31;
   localparam int LEVEL_W            = 8;
   localparam int CSR_DATA_W         = 32;
   localparam int CSR_ADDR_W         = 3;

   // register index, taken from paddr above the byte offset
   typedef enum logic [0:0] {
      REG_LEVEL_COUNT = 1'b0
   } csr_reg_type;

   localparam logic [LEVEL_W-1:0] LEVEL_COUNT_RESET = LEVEL_W'(1);

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   // per-cell control: shift the row towards the head, load the new partial sum
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

   function automatic logic signed [SUM_W-1:0] sat_add(
      input logic signed [SUM_W-1:0] a,
      input logic signed [SUM_W-1:0] b
   );
      logic signed [SUM_W:0] s;
      s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
      if (s[SUM_W] != s[SUM_W-1]) begin
         sat_add = s[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         sat_add = s[SUM_W-1:0];
      end
   endfunction

endpackage

/* rtl/core/triangle_max_path_sum.sv */
// Top level: greatest apex-to-bottom path sum of a number triangle.
//
// Elements arrive on the req_ channel, one per transfer, row by row and left
// to right (row r holds r+1 elements). After the last element of the last row
// one result, the best path sum floored at zero, leaves on the rsp_ channel.
// level_count (APB register at address 0) sets the number of rows; 0 counts
// as 1 and values above MAX_LEVELS count as MAX_LEVELS.
// Throughput is one element per cycle while no result waits. The stored row
// is a chain of cells: the head cell holds the parent above the incoming
// element when it has one; such an element shifts the chain by one, and every
// element loads its own partial sum at the tail, so the add and compare against
// two parents finish in the accepting cycle. The result is registered:
// rsp_valid rises in the cycle after the last element is accepted. A waiting
// result blocks input: req_ready is low while the result register is full and
// rsp_ready is low, so any element waits until the result leaves.
// Reset clears the row and column counters, the running best and the result
// valid flag, and sets level_count to 1 (the result value is not reset); the
// stored row needs no clearing since every entry is written before it is read.
module triangle_max_path_sum #(
   parameter int MAX_LEVELS = tmps_pkg::MAX_LEVELS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [tmps_pkg::VALUE_W-1:0]     req_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [tmps_pkg::BEST_W-1:0]             rsp_best_sum,
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [tmps_pkg::CSR_ADDR_W-1:0]         paddr,
   input  logic [tmps_pkg::CSR_DATA_W-1:0]         pwdata,
   output logic [tmps_pkg::CSR_DATA_W-1:0]         prdata,
   output logic                                    pready
);

   localparam int ROW_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int LVL_W = $clog2(MAX_LEVELS + 1);
   localparam int EXT_W = (LVL_W > tmps_pkg::LEVEL_W) ? LVL_W : tmps_pkg::LEVEL_W;

   // configuration
   logic [tmps_pkg::LEVEL_W-1:0] level_count_ff;
   logic [tmps_pkg::LEVEL_W-1:0] level_count_in;
   logic                         csr_write;
   tmps_pkg::csr_reg_type        csr_reg;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;
   assign csr_reg   = tmps_pkg::csr_reg_type'(paddr[2]);

   always_comb begin
      level_count_in = level_count_ff;
      if (csr_write && csr_reg == tmps_pkg::REG_LEVEL_COUNT) begin
         level_count_in = pwdata[tmps_pkg::LEVEL_W-1:0];
      end
   end

   always_comb begin
      case (csr_reg)
         tmps_pkg::REG_LEVEL_COUNT:
            prdata = tmps_pkg::CSR_DATA_W'(level_count_ff);
         default: prdata = '0;
      endcase
   end

   // running state
   logic [ROW_W-1:0]                   row_ff, row_in;
   logic [ROW_W-1:0]                   col_ff, col_in;
   logic signed [tmps_pkg::SUM_W-1:0]  hold_ff, hold_in;
   logic signed [tmps_pkg::SUM_W-1:0]  best_ff, best_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [tmps_pkg::BEST_W-1:0]        rsp_best_ff, rsp_best_in;

   logic signed [tmps_pkg::SUM_W-1:0]  cell_value [MAX_LEVELS];
   logic signed [tmps_pkg::SUM_W-1:0]  above;
   logic signed [tmps_pkg::SUM_W-1:0]  parent;
   logic signed [tmps_pkg::SUM_W-1:0]  value_ext;
   logic signed [tmps_pkg::SUM_W-1:0]  sum;
   logic signed [tmps_pkg::SUM_W-1:0]  best_next;
   logic [EXT_W-1:0]                   lc_ext;
   logic [EXT_W-1:0]                   levels;
   logic [EXT_W-1:0]                   row_plus;
   logic [ROW_W-1:0]                   wr_idx;
   logic                               req_fire;
   logic                               has_above;
   logic                               has_left;
   logic                               last_row;
   logic                               row_end;

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign req_fire  = req_valid & req_ready;

   assign lc_ext = EXT_W'(level_count_ff);

   always_comb begin
      if (lc_ext == '0) begin
         levels = EXT_W'(1);
      end else if (lc_ext > EXT_W'(MAX_LEVELS)) begin
         levels = EXT_W'(MAX_LEVELS);
      end else begin
         levels = lc_ext;
      end
   end

   assign above     = cell_value[0];
   assign has_above = col_ff < row_ff;
   assign has_left  = col_ff != '0;
   assign row_plus  = EXT_W'(row_ff) + EXT_W'(1);
   assign last_row  = row_plus >= levels;
   assign row_end   = ~has_above;
   assign value_ext = tmps_pkg::SUM_W'(req_value);

   // the head pops only while a parent above exists, so the tail slot moves
   assign wr_idx = has_above ? (row_ff - ROW_W'(1)) : row_ff;

   always_comb begin
      if (has_left && has_above) begin
         parent = (above > hold_ff) ? above : hold_ff;
      end else if (has_left) begin
         parent = hold_ff;
      end else begin
         parent = above;
      end
      if (has_left || has_above) begin
         sum = tmps_pkg::sat_add(parent, value_ext);
      end else begin
         sum = value_ext;
      end
      best_next = (last_row && sum > best_ff) ? sum : best_ff;
   end

   always_comb begin
      row_in       = row_ff;
      col_in       = col_ff;
      hold_in      = hold_ff;
      best_in      = best_ff;
      rsp_best_in  = rsp_best_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (req_fire) begin
         hold_in = above;
         best_in = best_next;
         if (row_end && last_row) begin
            // triangle done: emit and clear the run
            rsp_valid_in = 1'b1;
            rsp_best_in  = best_next[tmps_pkg::BEST_W-1:0];
            row_in       = '0;
            col_in       = '0;
            hold_in      = '0;
            best_in      = '0;
         end else if (row_end) begin
            row_in = row_ff + ROW_W'(1);
            col_in = '0;
         end else begin
            col_in = col_ff + ROW_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_count_ff <= tmps_pkg::LEVEL_COUNT_RESET;
         row_ff         <= '0;
         col_ff         <= '0;
         hold_ff        <= '0;
         best_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         level_count_ff <= level_count_in;
         row_ff         <= row_in;
         col_ff         <= col_in;
         hold_ff        <= hold_in;
         best_ff        <= best_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_best_ff <= rsp_best_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_best_sum = rsp_best_ff;

   // chain of cells holding the previous row, head at index 0
   for (genvar k = 0; k < MAX_LEVELS; k++) begin : g_cell
      tmps_pkg::cell_ctl_type             ctl;
      logic signed [tmps_pkg::SUM_W-1:0]  upstream;

      assign ctl.shift = req_fire & has_above;
      assign ctl.load  = req_fire & (wr_idx == ROW_W'(k));

      if (k == MAX_LEVELS - 1) begin : g_last
         assign upstream = cell_value[k];
      end else begin : g_mid
         assign upstream = cell_value[k+1];
      end

      tmps_cell u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .upstream (upstream),
         .new_sum  (sum),
         .value    (cell_value[k])
      );
   end

endmodule

/* rtl/core/tmps_cell.sv */
// One cell of the stored row of best partial sums.
module tmps_cell (
   input  logic                                clock,
   input  tmps_pkg::cell_ctl_type              ctl,
   input  logic signed [tmps_pkg::SUM_W-1:0]   upstream,
   input  logic signed [tmps_pkg::SUM_W-1:0]   new_sum,
   output logic signed [tmps_pkg::SUM_W-1:0]   value
);

   logic signed [tmps_pkg::SUM_W-1:0] value_ff;
   logic signed [tmps_pkg::SUM_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (ctl.load) begin
         value_in = new_sum;
      end else if (ctl.shift) begin
         value_in = upstream;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

/* rtl/core/tmps_checker.sv */
// Port-level checks for the path-sum block, bound to the top level.
module tmps_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [tmps_pkg::BEST_W-1:0]       rsp_best_sum,
   input logic                              pready
);

   // a stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_best_sum))
      else $error("result dropped or changed while stalled");

   // no result is left over from before reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a new result follows an accepted element
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("result without an accepted element");

   // input stalls only while a finished result still waits
   a_req_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not follow result register");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("pready low");

endmodule

bind triangle_max_path_sum tmps_checker u_tmps_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_best_sum (rsp_best_sum),
   .pready       (pready)
);
